// File: rtl/mse_pkg.sv
package mse_pkg;

	localparam int MEM_BYTES_DEF = 1024;

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_AND = 6'd3, OP_OR = 6'd4,
		OP_XOR = 6'd5, OP_NOR = 6'd6, OP_NAND = 6'd7, OP_SLT = 6'd8, OP_SLL = 6'd9,
		OP_SRL = 6'd10, OP_SRA = 6'd11, OP_JR = 6'd12, OP_ADDI = 6'd13,
		OP_ADDIU = 6'd14, OP_LW = 6'd15, OP_LH = 6'd16, OP_LHU = 6'd17,
		OP_LB = 6'd18, OP_LBU = 6'd19, OP_SW = 6'd20, OP_SH = 6'd21, OP_SB = 6'd22,
		OP_LUI = 6'd23, OP_ANDI = 6'd24, OP_ORI = 6'd25, OP_NORI = 6'd26,
		OP_SLTI = 6'd27, OP_BEQ = 6'd28, OP_BNE = 6'd29, OP_BGTZ = 6'd30,
		OP_J = 6'd31, OP_JAL = 6'd32
	} op_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic        zero_write_flag;
		logic        overflow_flag;
		logic        range_fault;
		logic        align_fault;
		logic        halted;
	} res_t;

endpackage

// File: rtl/mips_subset_execute_top.sv
// mips_subset_execute_top: executes one decoded instruction per request.
// Input stream s_axis_*: tdata = {jump_target, imm16, shift_amount,
// dest_reg, second_reg, src_reg, opcode} (opcode in the low bits).
// Output stream m_axis_*: tdata = {halted, align_fault, range_fault,
// overflow_flag, zero_write_flag, written_value, written_index,
// reg_written, next_pc} (next_pc in the low bits).
// start_address is written through cfg_we/cfg_data and is cleared by reset
// like the PC; the PC copies it as the memory clear begins, while it
// still holds its reset value, so a later write does not move the PC.
// Each instruction is handled in a read step on the register file and
// data memory (synchronous read), then a compute and write-back step.
// A new instruction is accepted only once the previous one has left the
// read stage. The result is registered in the output register, which an
// instruction enters from the read stage only while it is free or read out.
// After reset the data memory is cleared one word per cycle (all
// MEM_BYTES/4 words, 256 at the default size) while s_axis_tready is low.
// The result sits in an output register; while the receiver stalls, one
// further instruction may be read and waits in the execute stage.
// Register file clears on reset via per-entry valid bits.
module mips_subset_execute_top
	import mse_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode, src_reg, second_reg, dest_reg, shift_amount, imm16, jump_target
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// next_pc, reg_written, written_index, written_value, zero_write_flag,
	// overflow_flag, range_fault, align_fault, halted
	output logic [79:0]  m_axis_tdata
);

	localparam int WORDS = MEM_BYTES / 4;
	localparam int WAW = $clog2(WORDS);
	localparam int CW = $clog2(WORDS + 1);

	logic [31:0] start_q, pc_q;
	logic [31:0] rf [32];
	logic [31:0] rf_vld_q;
	logic [31:0] dmem [WORDS];
	logic [CW-1:0] clr_q;
	logic clearing;

	// stage 1: read issued
	logic        v_s1;
	logic [71:0] d_s1;
	logic [31:0] a_s1, b_s1, w_s1;
	logic        av_s1, bv_s1;
	// output
	logic        ov_q;
	res_t        out_q;

	assign clearing = (clr_q != CW'(WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= '0;
		else if (cfg_we) start_q <= cfg_data;
	end

	// decode of incoming item for read address
	logic [4:0]  in_rs, in_rt;
	logic [15:0] in_imm;
	logic [31:0] in_a, in_addr;
	assign in_rs = s_axis_tdata[10:6];
	assign in_rt = s_axis_tdata[15:11];
	assign in_imm = s_axis_tdata[41:26];

	// execute stage signals
	logic        ex_fire, acc;
	logic [5:0]  op;
	logic [4:0]  rt, rd, sh;
	logic [15:0] imm;
	logic [25:0] tgt;
	logic [31:0] a, b, se, pc4, boff, npc, v, addr, sum;
	logic        wr, zf, ovf, rng, aln, mem_op, ld_ok, st_en;
	logic [4:0]  widx;
	logic [2:0]  nbytes;
	logic [32:0] endp;
	logic [31:0] wword, wnew;
	logic [1:0]  bo;
	logic [7:0]  lbyte;
	logic [15:0] lhalf;

	// items enter only when stage 1 is empty
	assign ex_fire = v_s1 && (!ov_q || m_axis_tready);
	assign s_axis_tready = !clearing && !v_s1;
	assign acc = s_axis_tvalid && s_axis_tready;

	assign op = d_s1[5:0];
	assign rt = d_s1[15:11];
	assign rd = d_s1[20:16];
	assign sh = d_s1[25:21];
	assign imm = d_s1[41:26];
	assign tgt = d_s1[67:42];
	assign a = av_s1 ? a_s1 : '0;
	assign b = bv_s1 ? b_s1 : '0;
	assign se = {{16{imm[15]}}, imm};
	assign pc4 = pc_q + 32'd4;
	assign boff = pc4 + {se[29:0], 2'b00};
	assign addr = a + se;
	assign bo = addr[1:0];
	assign lbyte = w_s1[8*(3-bo) +: 8];
	assign lhalf = bo[1] ? w_s1[15:0] : w_s1[31:16];

	always_comb begin
		sum = a + b;
		npc = pc4; wr = 1'b0; widx = '0; v = '0; zf = 1'b0; ovf = 1'b0;
		rng = 1'b0; aln = 1'b0; mem_op = 1'b0; nbytes = 3'd1; st_en = 1'b0;
		wnew = w_s1;
		case (op) inside
			OP_LW, OP_SW: nbytes = 3'd4;
			OP_LH, OP_LHU, OP_SH: nbytes = 3'd2;
			default: nbytes = 3'd1;
		endcase
		endp = {1'b0, addr} + {30'd0, nbytes};
		unique case (op) inside
			OP_ADD: begin
				wr = 1'b1; widx = rd; v = sum;
				ovf = (a[31] == b[31]) && (sum[31] != a[31]);
			end
			OP_ADDU: begin wr = 1'b1; widx = rd; v = sum; end
			OP_SUB: begin
				wr = 1'b1; widx = rd; v = a - b;
				ovf = (a[31] != b[31]) && (v[31] != a[31]);
			end
			OP_AND: begin wr = 1'b1; widx = rd; v = a & b; end
			OP_OR: begin wr = 1'b1; widx = rd; v = a | b; end
			OP_XOR: begin wr = 1'b1; widx = rd; v = a ^ b; end
			OP_NOR: begin wr = 1'b1; widx = rd; v = ~(a | b); end
			OP_NAND: begin wr = 1'b1; widx = rd; v = ~(a & b); end
			OP_SLT: begin wr = 1'b1; widx = rd; v = {31'd0, $signed(a) < $signed(b)}; end
			OP_SLL: begin
				wr = !(rt == 5'd0 && sh == 5'd0 && rd == 5'd0); widx = rd; v = b << sh;
			end
			OP_SRL: begin wr = 1'b1; widx = rd; v = b >> sh; end
			OP_SRA: begin wr = 1'b1; widx = rd; v = 32'($signed(b) >>> sh); end
			OP_JR: npc = a;
			OP_ADDI: begin
				wr = 1'b1; widx = rt; v = addr;
				ovf = (a[31] == se[31]) && (addr[31] != a[31]);
			end
			OP_ADDIU: begin wr = 1'b1; widx = rt; v = addr; end
			OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: begin
				mem_op = 1'b1;
				ovf = (a[31] == se[31]) && (addr[31] != a[31]);
				rng = endp > 33'(MEM_BYTES);
				aln = ((addr[1:0] & 2'(nbytes - 3'd1)) != 2'd0);
			end
			OP_LUI: begin wr = 1'b1; widx = rt; v = {imm, 16'd0}; end
			OP_ANDI: begin wr = 1'b1; widx = rt; v = a & {16'd0, imm}; end
			OP_ORI: begin wr = 1'b1; widx = rt; v = a | {16'd0, imm}; end
			OP_NORI: begin wr = 1'b1; widx = rt; v = ~(a | {16'd0, imm}); end
			OP_SLTI: begin wr = 1'b1; widx = rt; v = {31'd0, $signed(a) < $signed(se)}; end
			OP_BEQ: if (a == b) npc = boff;
			OP_BNE: if (a != b) npc = boff;
			OP_BGTZ: if (a != 32'd0 && !a[31]) npc = boff;
			OP_J: npc = {pc4[31:28], tgt, 2'b00};
			OP_JAL: begin
				wr = 1'b1; widx = 5'd31; v = pc4; npc = {pc4[31:28], tgt, 2'b00};
			end
			default: ;
		endcase
		ld_ok = mem_op && !rng && !aln;
		case (op)
			OP_LW: v = w_s1;
			OP_LH: v = {{16{lhalf[15]}}, lhalf};
			OP_LHU: v = {16'd0, lhalf};
			OP_LB: v = {{24{lbyte[7]}}, lbyte};
			OP_LBU: v = {24'd0, lbyte};
			OP_SW: begin st_en = ld_ok; wnew = b; end
			OP_SH: begin
				st_en = ld_ok;
				if (bo[1]) wnew[15:0] = b[15:0];
				else wnew[31:16] = b[15:0];
			end
			OP_SB: begin st_en = ld_ok; wnew[8*(3-bo) +: 8] = b[7:0]; end
			default: ;
		endcase
		if (mem_op && op <= OP_LBU) begin
			wr = ld_ok; widx = rt;
			zf = (rt == 5'd0);
		end
		if (wr) begin
			zf = (widx == 5'd0) && (op != OP_JAL);
			if (widx == 5'd0) v = '0;
		end else begin
			widx = '0; v = '0;
		end
	end

	// register file with valid bits
	always_ff @(posedge clk) begin
		if (acc) begin
			a_s1 <= rf[in_rs];
			b_s1 <= rf[in_rt];
		end
		if (ex_fire && wr) rf[widx] <= v;
	end

	// data memory: big-endian words, cleared after reset
	assign in_a = rf_vld_q[in_rs] ? rf[in_rs] : '0;
	assign in_addr = in_a + {{16{in_imm[15]}}, in_imm};
	always_ff @(posedge clk) begin
		if (clearing) dmem[clr_q[WAW-1:0]] <= '0;
		else if (ex_fire && st_en) dmem[addr[WAW+1:2]] <= wnew;
		if (acc) w_s1 <= dmem[in_addr[WAW+1:2]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			clr_q <= '0;
			pc_q <= '0;
			v_s1 <= 1'b0;
			av_s1 <= 1'b0;
			bv_s1 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CW'(1);
				if (clr_q == '0) pc_q <= start_q;
			end
			if (acc) begin
				v_s1 <= 1'b1;
				av_s1 <= rf_vld_q[in_rs];
				bv_s1 <= rf_vld_q[in_rt];
			end else if (ex_fire) begin
				v_s1 <= 1'b0;
			end
			if (ex_fire) begin
				pc_q <= npc;
				if (wr) rf_vld_q[widx] <= 1'b1;
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) d_s1 <= s_axis_tdata;
		if (ex_fire) begin
			out_q.next_pc <= npc;
			out_q.reg_written <= wr;
			out_q.written_index <= widx;
			out_q.written_value <= v;
			out_q.zero_write_flag <= zf;
			out_q.overflow_flag <= ovf;
			out_q.range_fault <= rng;
			out_q.align_fault <= aln;
			out_q.halted <= rng || aln;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {5'd0, out_q.halted, out_q.align_fault, out_q.range_fault,
		out_q.overflow_flag, out_q.zero_write_flag, out_q.written_value,
		out_q.written_index, out_q.reg_written, out_q.next_pc};

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !acc) else $error("accept during clear");
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1 && !s_axis_tready) else $error("stage 1 overrun");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !m_axis_tready |=> ov_q && $stable(out_q)) else $error("result lost");
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		ex_fire && (rng || aln) |-> !st_en && !(mem_op && wr)) else $error("fault access");

endmodule
